### rtl/arc_length_polyline_sampler_defines.svh
// Assertion macros shared by the checker of the arc-length polyline sampler.
// Needs a clock named clock and a reset named reset in the using scope.
`ifndef ARC_LENGTH_POLYLINE_SAMPLER_DEFINES_SVH
`define ARC_LENGTH_POLYLINE_SAMPLER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ALPS_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("alps port check failed");

// The consequent must hold in the cycle after the antecedent.
`define ALPS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("alps port check failed");

`endif

### rtl/alps_pkg.sv
`timescale 1ns / 1ps
// Types, constants and helper functions of the arc-length polyline sampler.
// No dependencies; every module of the block but alps_ram imports this package.
package alps_pkg;

   localparam int MAX_ANCHORS     = 256;
   localparam int DEPTH           = MAX_ANCHORS + 1;
   localparam int IDX_W           = $clog2(DEPTH);
   localparam int CNT_W           = $clog2(DEPTH + 1);
   localparam int WORD_W          = 32;
   localparam int DWORD_W         = 2 * WORD_W;
   localparam int SUM_W           = DWORD_W + 2;
   localparam int CSR_DATA_W      = 16;
   localparam int ANCHOR_COUNT_W  = 9;
   localparam int FRAC_W          = 16;

   typedef enum logic [1:0] {
      FUNC_CLEAR,
      FUNC_APPEND,
      FUNC_POSITION,
      FUNC_TANGENT
   } func_type;

   typedef enum logic [1:0] {
      ST_OK,
      ST_EMPTY,
      ST_FULL,
      ST_DUPLICATE
   } status_type;

   typedef enum logic {
      CSR_CLOSED_LOOP,
      CSR_DUP_LIMIT
   } csr_index_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_DECODE,
      S_APP_CLOSE0,
      S_APP_LAST,
      S_DIST_MUL,
      S_DIST_MW,
      S_DIST_SQ,
      S_DIST_SW,
      S_APP_DEC,
      S_APP_ZERO,
      S_MOD_W,
      S_SRCH,
      S_SRCH_W,
      S_RD_A,
      S_RD_B,
      S_TAN_P,
      S_TAN_R,
      S_TAN_W,
      S_TAN_DIV,
      S_TAN_DW,
      S_LERP,
      S_LERP_MW,
      S_LERP_DW
   } state_type;

   typedef struct packed {
      logic [WORD_W-1:0] x;
      logic [WORD_W-1:0] y;
      logic [WORD_W-1:0] z;
      logic [WORD_W-1:0] d;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   function automatic logic [WORD_W-1:0] ent_coord(entry_type e, logic [1:0] c);
      logic [WORD_W-1:0] v;
      case (c)
         2'd0:    v = e.x;
         2'd1:    v = e.y;
         default: v = e.z;
      endcase
      return v;
   endfunction

   function automatic logic [WORD_W:0] sub33(logic [WORD_W-1:0] a, logic [WORD_W-1:0] b);
      return {a[WORD_W-1], a} - {b[WORD_W-1], b};
   endfunction

   function automatic logic [WORD_W-1:0] mag33(logic [WORD_W:0] d);
      logic [WORD_W:0] m;
      m = d[WORD_W] ? (~d + 1'b1) : d;
      return m[WORD_W-1:0];
   endfunction

   function automatic logic [WORD_W-1:0] sat_add32(logic [WORD_W-1:0] a,
                                                   logic [WORD_W-1:0] b);
      logic [WORD_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[WORD_W] ? {WORD_W{1'b1}} : s[WORD_W-1:0];
   endfunction

endpackage

### rtl/alps_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module alps_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/alps_mul.sv
`timescale 1ns / 1ps
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle.
// Depends on alps_pkg.
module alps_mul import alps_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [WORD_W-1:0]  op_a,
   input  logic [WORD_W-1:0]  op_b,
   output logic               done,
   output logic [DWORD_W-1:0] product
);

   localparam int STEP_W = $clog2(WORD_W);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [STEP_W-1:0]  cnt_ff, cnt_in;
   logic [WORD_W-1:0]  a_ff, a_in;
   logic [DWORD_W-1:0] prod_ff, prod_in;
   logic [WORD_W:0]    upper;

   always_comb begin
      upper   = {1'b0, prod_ff[DWORD_W-1:WORD_W]} +
                (prod_ff[0] ? {1'b0, a_ff} : {(WORD_W+1){1'b0}});
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      a_in    = a_ff;
      prod_in = prod_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         a_in    = op_a;
         prod_in = {{WORD_W{1'b0}}, op_b};
      end else if (busy_ff) begin
         prod_in = {upper, prod_ff[WORD_W-1:1]};
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == STEP_W'(WORD_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      a_ff    <= a_in;
      prod_ff <= prod_in;
   end

   assign done    = done_ff;
   assign product = prod_ff;

endmodule

### rtl/alps_div.sv
`timescale 1ns / 1ps
// Bit-serial restoring divider, 64 by 32 bits, one quotient bit per cycle.
// Depends on alps_pkg.
module alps_div import alps_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [DWORD_W-1:0] dividend,
   input  logic [WORD_W-1:0]  divisor,
   output logic               done,
   output logic [DWORD_W-1:0] quotient,
   output logic [WORD_W-1:0]  remainder
);

   localparam int STEP_W = $clog2(DWORD_W);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [STEP_W-1:0]  cnt_ff, cnt_in;
   logic [WORD_W-1:0]  div_ff, div_in;
   logic [WORD_W-1:0]  rem_ff, rem_in;
   logic [DWORD_W-1:0] quo_ff, quo_in;
   logic [WORD_W:0]    trial;
   logic [WORD_W:0]    diff;
   logic               ge;

   always_comb begin
      trial   = {rem_ff, quo_ff[DWORD_W-1]};
      diff    = trial - {1'b0, div_ff};
      ge      = trial >= {1'b0, div_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      div_in  = div_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         div_in  = divisor;
         rem_in  = '0;
         quo_in  = dividend;
      end else if (busy_ff) begin
         rem_in = ge ? diff[WORD_W-1:0] : trial[WORD_W-1:0];
         quo_in = {quo_ff[DWORD_W-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == STEP_W'(DWORD_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      div_ff <= div_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

### rtl/alps_sqrt.sv
`timescale 1ns / 1ps
// Digit-serial integer square root, two radicand bits and one root bit a cycle.
// Depends on alps_pkg.
module alps_sqrt import alps_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [DWORD_W-1:0] radicand,
   output logic               done,
   output logic [WORD_W-1:0]  root
);

   localparam int STEP_W = $clog2(WORD_W);
   localparam int REM_W  = WORD_W + 2;

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [STEP_W-1:0]  cnt_ff, cnt_in;
   logic [REM_W-1:0]   rem_ff, rem_in;
   logic [DWORD_W-1:0] rad_ff, rad_in;
   logic [WORD_W-1:0]  root_ff, root_in;
   logic [REM_W+1:0]   cur;
   logic [REM_W+1:0]   trial;
   logic [REM_W+1:0]   diff;
   logic               ge;

   always_comb begin
      cur     = {rem_ff, rad_ff[DWORD_W-1:DWORD_W-2]};
      trial   = {2'b00, root_ff, 2'b01};
      diff    = cur - trial;
      ge      = cur >= trial;
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      rad_in  = rad_ff;
      root_in = root_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         rad_in  = radicand;
         root_in = '0;
      end else if (busy_ff) begin
         rem_in  = ge ? diff[REM_W-1:0] : cur[REM_W-1:0];
         rad_in  = {rad_ff[DWORD_W-3:0], 2'b00};
         root_in = {root_ff[WORD_W-2:0], ge};
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == STEP_W'(WORD_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      rem_ff  <= rem_in;
      rad_ff  <= rad_in;
      root_ff <= root_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

### rtl/arc_length_polyline_sampler.sv
`timescale 1ns / 1ps
// Top level of the arc-length polyline sampler: sequencer, anchor store and serial units.
// Depends on alps_pkg, alps_ram, alps_mul, alps_div and alps_sqrt.
//
//   channel   ports                         handshake
//   request   start, busy, req_*            beat taken when start and not busy
//   response  rsp_valid, rsp_*              one-cycle strobe, cannot be held off
//   config    csr_wr_en, csr_index, csr_*   write taken when csr_wr_en is high
//
// Busy is shortest for a clear, an append to a full store or a first anchor (longer when closed);
// any other append runs the serial multiplier and square root (twice over when closed), a position
// query a binary search and a multiply and divide per axis, plus a modulo divide for the wrap when
// closed, and a tangent divides for its end tangents too; the strobe follows the last busy cycle.
// Reset is synchronous and leaves an empty open curve; the receiver cannot stall and the
// anchor store needs no clearing pass.
module arc_length_polyline_sampler import alps_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic [1:0]                req_func,
   input  logic signed [WORD_W-1:0]  req_x_coord,
   input  logic signed [WORD_W-1:0]  req_y_coord,
   input  logic signed [WORD_W-1:0]  req_z_coord,
   input  logic                      req_force_append,
   input  logic signed [WORD_W-1:0]  req_query_param,
   output logic                      rsp_valid,
   output logic signed [WORD_W-1:0]  rsp_out_x,
   output logic signed [WORD_W-1:0]  rsp_out_y,
   output logic signed [WORD_W-1:0]  rsp_out_z,
   output logic [1:0]                rsp_status,
   output logic [WORD_W-1:0]         rsp_total_length,
   output logic [ANCHOR_COUNT_W-1:0] rsp_anchor_count,
   input  logic                      csr_wr_en,
   input  logic                      csr_index,
   input  logic [CSR_DATA_W-1:0]     csr_wr_data
);

   state_type              state_ff, state_in;
   func_type               func_ff, func_in;
   entry_type              new_ff, new_in;
   logic                   force_ff, force_in;
   logic [WORD_W-1:0]      qparam_ff, qparam_in;
   logic                   closed_ff;
   logic [CSR_DATA_W-1:0]  dup_ff;
   logic                   mode_ff, mode_in;
   logic [CNT_W-1:0]       stored_ff, stored_in;
   logic [WORD_W-1:0]      total_ff, total_in;
   status_type             status_ff, status_in;
   entry_type              ent_a_ff, ent_a_in;
   entry_type              ent_b_ff, ent_b_in;
   logic [IDX_W-1:0]       a_idx_ff, a_idx_in;
   logic [IDX_W-1:0]       b_idx_ff, b_idx_in;
   logic [IDX_W-1:0]       k_ff, k_in;
   logic [WORD_W-1:0]      t_ff, t_in;
   logic [WORD_W-1:0]      num_ff, num_in;
   logic [WORD_W-1:0]      span_ff, span_in;
   logic [WORD_W-1:0]      len_ff, len_in;
   logic [SUM_W-1:0]       sum_ff, sum_in;
   logic [1:0]             coord_ff, coord_in;
   logic                   phase_ff, phase_in;
   logic                   tsel_ff, tsel_in;
   logic [2:0][WORD_W-1:0] tan0_ff, tan0_in;
   logic [2:0][WORD_W-1:0] tan1_ff, tan1_in;
   logic [2:0][WORD_W-1:0] res_ff, res_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [2:0][WORD_W-1:0] rsp_res_ff, rsp_res_in;
   status_type             rsp_status_ff, rsp_status_in;
   logic [WORD_W-1:0]      rsp_total_ff, rsp_total_in;
   logic [ANCHOR_COUNT_W-1:0] rsp_count_ff, rsp_count_in;

   logic                   ram_wr_en;
   logic [IDX_W-1:0]       ram_wr_addr;
   entry_type              ram_wr_data;
   logic [IDX_W-1:0]       ram_rd_addr;
   entry_type              ram_rd_data;

   logic                   mul_start, mul_done;
   logic [WORD_W-1:0]      mul_a, mul_b;
   logic [DWORD_W-1:0]     mul_product;
   logic                   div_start, div_done;
   logic [DWORD_W-1:0]     div_dividend, div_quotient;
   logic [WORD_W-1:0]      div_divisor, div_remainder;
   logic                   sqrt_start, sqrt_done;
   logic [DWORD_W-1:0]     sqrt_radicand;
   logic [WORD_W-1:0]      sqrt_root;

   logic [CNT_W-1:0]       real_w;
   logic [CNT_W-1:0]       real_next;
   logic                   finish;
   logic [WORD_W:0]        dist_diff;
   logic [WORD_W-1:0]      q_mag;
   logic [IDX_W-1:0]       cur_idx;
   logic [IDX_W-1:0]       tan_p_idx;
   logic [IDX_W-1:0]       tan_r_idx;
   logic [WORD_W:0]        tan_diff;
   logic [WORD_W-1:0]      tan_w;
   logic [WORD_W-1:0]      tan_sat;
   logic [WORD_W-1:0]      lerp_lo;
   logic [WORD_W-1:0]      lerp_hi;
   logic [WORD_W:0]        lerp_diff;
   logic [WORD_W-1:0]      app_sum;
   logic [IDX_W:0]         idx_sum;

   alps_ram #(.WIDTH(ENTRY_W), .DEPTH(DEPTH)) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   alps_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .done    (mul_done),
      .product (mul_product)
   );

   alps_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .quotient  (div_quotient),
      .remainder (div_remainder)
   );

   alps_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (sqrt_radicand),
      .done     (sqrt_done),
      .root     (sqrt_root)
   );

   assign real_w    = stored_ff - CNT_W'(mode_ff && (stored_ff != '0));
   assign dist_diff = sub33(ent_coord(new_ff, coord_ff),
                            ent_coord(phase_ff ? ent_b_ff : ent_a_ff, coord_ff));
   assign q_mag     = mag33({qparam_ff[WORD_W-1], qparam_ff});
   assign cur_idx   = tsel_ff ? b_idx_ff : a_idx_ff;
   assign tan_p_idx = cur_idx - IDX_W'(cur_idx != '0);
   assign tan_r_idx = cur_idx + IDX_W'((CNT_W+1)'(cur_idx) + 1'b1 < (CNT_W+1)'(stored_ff));
   assign tan_diff  = sub33(ent_coord(ent_b_ff, coord_ff), ent_coord(ent_a_ff, coord_ff));
   assign tan_w     = ent_b_ff.d - ent_a_ff.d;
   assign lerp_lo   = (func_ff == FUNC_POSITION) ? ent_coord(ent_a_ff, coord_ff)
                                                 : (tsel_ff ? tan0_ff[coord_ff]
                                                            : tan0_ff[coord_ff]);
   assign lerp_hi   = (func_ff == FUNC_POSITION) ? ent_coord(ent_b_ff, coord_ff)
                                                 : tan1_ff[coord_ff];
   assign lerp_diff = sub33(lerp_hi, lerp_lo);
   assign app_sum   = sat_add32(phase_ff ? total_ff : ent_a_ff.d, len_ff);
   assign idx_sum   = {1'b0, a_idx_ff} + {1'b0, b_idx_ff};

   always_comb begin
      if (tan_diff[WORD_W]) begin
         if (div_quotient > DWORD_W'(33'h080000000)) begin
            tan_sat = {1'b1, {(WORD_W-1){1'b0}}};
         end else begin
            tan_sat = ~div_quotient[WORD_W-1:0] + 1'b1;
         end
      end else begin
         if (div_quotient > DWORD_W'(33'h07FFFFFFF)) begin
            tan_sat = {1'b0, {(WORD_W-1){1'b1}}};
         end else begin
            tan_sat = div_quotient[WORD_W-1:0];
         end
      end
   end

   always_comb begin
      state_in      = state_ff;
      func_in       = func_ff;
      new_in        = new_ff;
      force_in      = force_ff;
      qparam_in     = qparam_ff;
      mode_in       = mode_ff;
      stored_in     = stored_ff;
      total_in      = total_ff;
      status_in     = status_ff;
      ent_a_in      = ent_a_ff;
      ent_b_in      = ent_b_ff;
      a_idx_in      = a_idx_ff;
      b_idx_in      = b_idx_ff;
      k_in          = k_ff;
      t_in          = t_ff;
      num_in        = num_ff;
      span_in       = span_ff;
      len_in        = len_ff;
      sum_in        = sum_ff;
      coord_in      = coord_ff;
      phase_in      = phase_ff;
      tsel_in       = tsel_ff;
      tan0_in       = tan0_ff;
      tan1_in       = tan1_ff;
      res_in        = res_ff;
      rsp_valid_in  = 1'b0;
      rsp_res_in    = rsp_res_ff;
      rsp_status_in = rsp_status_ff;
      rsp_total_in  = rsp_total_ff;
      rsp_count_in  = rsp_count_ff;
      finish        = 1'b0;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = '0;
      ram_wr_data   = new_ff;
      ram_rd_addr   = '0;
      mul_start     = 1'b0;
      mul_a         = mag33(dist_diff);
      mul_b         = mag33(dist_diff);
      div_start     = 1'b0;
      div_dividend  = mul_product;
      div_divisor   = span_ff;
      sqrt_start    = 1'b0;
      sqrt_radicand = sum_ff[DWORD_W-1:0];

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               func_in   = func_type'(req_func);
               new_in    = {req_x_coord, req_y_coord, req_z_coord, {WORD_W{1'b0}}};
               force_in  = req_force_append;
               qparam_in = req_query_param;
               state_in  = S_DECODE;
            end
         end
         S_DECODE: begin
            res_in    = '0;
            status_in = ST_OK;
            phase_in  = 1'b0;
            case (func_ff)
               FUNC_CLEAR: begin
                  stored_in = '0;
                  mode_in   = closed_ff;
                  total_in  = '0;
                  finish    = 1'b1;
               end
               FUNC_APPEND: begin
                  if (stored_ff == '0) begin
                     ram_wr_en   = 1'b1;
                     ram_wr_addr = '0;
                     total_in    = '0;
                     if (mode_ff) begin
                        stored_in = CNT_W'(2);
                        state_in  = S_APP_CLOSE0;
                     end else begin
                        stored_in = CNT_W'(1);
                        finish    = 1'b1;
                     end
                  end else if (real_w >= CNT_W'(MAX_ANCHORS)) begin
                     status_in = ST_FULL;
                     finish    = 1'b1;
                  end else begin
                     ram_rd_addr = IDX_W'(real_w - 1'b1);
                     state_in    = S_APP_LAST;
                  end
               end
               default: begin
                  a_idx_in = '0;
                  b_idx_in = IDX_W'(stored_ff - 1'b1);
                  if (stored_ff == '0) begin
                     status_in = ST_EMPTY;
                     finish    = 1'b1;
                  end else if (mode_ff) begin
                     if (total_ff == '0) begin
                        t_in     = '0;
                        state_in = S_SRCH;
                     end else begin
                        div_start    = 1'b1;
                        div_dividend = {{WORD_W{1'b0}}, q_mag};
                        div_divisor  = total_ff;
                        state_in     = S_MOD_W;
                     end
                  end else begin
                     if (qparam_ff[WORD_W-1]) begin
                        t_in = '0;
                     end else if (qparam_ff > total_ff) begin
                        t_in = total_ff;
                     end else begin
                        t_in = qparam_ff;
                     end
                     state_in = S_SRCH;
                  end
               end
            endcase
         end
         S_APP_CLOSE0: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = IDX_W'(1);
            finish      = 1'b1;
         end
         S_APP_LAST: begin
            ent_a_in = ram_rd_data;
            coord_in = '0;
            sum_in   = '0;
            state_in = S_DIST_MUL;
         end
         S_DIST_MUL: begin
            mul_start = 1'b1;
            state_in  = S_DIST_MW;
         end
         S_DIST_MW: begin
            if (mul_done) begin
               sum_in = sum_ff + SUM_W'(mul_product);
               if (coord_ff == 2'd2) begin
                  state_in = S_DIST_SQ;
               end else begin
                  coord_in = coord_ff + 1'b1;
                  state_in = S_DIST_MUL;
               end
            end
         end
         S_DIST_SQ: begin
            if (sum_ff[SUM_W-1:DWORD_W] != '0) begin
               len_in   = {WORD_W{1'b1}};
               state_in = S_APP_DEC;
            end else begin
               sqrt_start = 1'b1;
               state_in   = S_DIST_SW;
            end
         end
         S_DIST_SW: begin
            if (sqrt_done) begin
               len_in   = sqrt_root;
               state_in = S_APP_DEC;
            end
         end
         S_APP_DEC: begin
            if (!phase_ff) begin
               if (!force_ff && (len_ff < WORD_W'(dup_ff))) begin
                  status_in = ST_DUPLICATE;
                  finish    = 1'b1;
               end else begin
                  ram_wr_en   = 1'b1;
                  ram_wr_addr = IDX_W'(real_w);
                  ram_wr_data = {new_ff.x, new_ff.y, new_ff.z, app_sum};
                  total_in    = app_sum;
                  if (mode_ff) begin
                     ram_rd_addr = '0;
                     state_in    = S_APP_ZERO;
                  end else begin
                     stored_in = real_w + 1'b1;
                     finish    = 1'b1;
                  end
               end
            end else begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = IDX_W'(real_w + 1'b1);
               ram_wr_data = {ent_b_ff.x, ent_b_ff.y, ent_b_ff.z, app_sum};
               total_in    = app_sum;
               stored_in   = real_w + CNT_W'(2);
               finish      = 1'b1;
            end
         end
         S_APP_ZERO: begin
            ent_b_in = ram_rd_data;
            phase_in = 1'b1;
            coord_in = '0;
            sum_in   = '0;
            state_in = S_DIST_MUL;
         end
         S_MOD_W: begin
            if (div_done) begin
               if (qparam_ff[WORD_W-1] && (div_remainder != '0)) begin
                  t_in = total_ff - div_remainder;
               end else begin
                  t_in = div_remainder;
               end
               state_in = S_SRCH;
            end
         end
         S_SRCH: begin
            if (b_idx_ff - a_idx_ff > IDX_W'(1)) begin
               k_in        = idx_sum[IDX_W:1];
               ram_rd_addr = idx_sum[IDX_W:1];
               state_in    = S_SRCH_W;
            end else begin
               ram_rd_addr = a_idx_ff;
               state_in    = S_RD_A;
            end
         end
         S_SRCH_W: begin
            if (ram_rd_data.d > t_ff) begin
               b_idx_in = k_ff;
            end else begin
               a_idx_in = k_ff;
            end
            state_in = S_SRCH;
         end
         S_RD_A: begin
            ent_a_in    = ram_rd_data;
            ram_rd_addr = b_idx_ff;
            state_in    = S_RD_B;
         end
         S_RD_B: begin
            ent_b_in = ram_rd_data;
            num_in   = t_ff - ent_a_ff.d;
            span_in  = ram_rd_data.d - ent_a_ff.d;
            coord_in = '0;
            tsel_in  = 1'b0;
            state_in = (func_ff == FUNC_POSITION) ? S_LERP : S_TAN_P;
         end
         S_TAN_P: begin
            ram_rd_addr = tan_p_idx;
            state_in    = S_TAN_R;
         end
         S_TAN_R: begin
            ent_a_in    = ram_rd_data;
            ram_rd_addr = tan_r_idx;
            state_in    = S_TAN_W;
         end
         S_TAN_W: begin
            ent_b_in = ram_rd_data;
            coord_in = '0;
            state_in = S_TAN_DIV;
         end
         S_TAN_DIV, S_TAN_DW: begin
            if ((state_ff == S_TAN_DIV) && (tan_w != '0)) begin
               div_start    = 1'b1;
               div_dividend = {{FRAC_W{1'b0}}, mag33(tan_diff), {FRAC_W{1'b0}}};
               div_divisor  = tan_w;
               state_in     = S_TAN_DW;
            end else if ((state_ff == S_TAN_DIV) || div_done) begin
               if (tsel_ff) begin
                  tan1_in[coord_ff] = (tan_w == '0) ? '0 : tan_sat;
               end else begin
                  tan0_in[coord_ff] = (tan_w == '0) ? '0 : tan_sat;
               end
               if (coord_ff == 2'd2) begin
                  coord_in = '0;
                  if (tsel_ff) begin
                     state_in = S_LERP;
                  end else begin
                     tsel_in  = 1'b1;
                     state_in = S_TAN_P;
                  end
               end else begin
                  coord_in = coord_ff + 1'b1;
                  state_in = S_TAN_DIV;
               end
            end
         end
         S_LERP, S_LERP_DW: begin
            if ((state_ff == S_LERP) && (span_ff != '0)) begin
               mul_start = 1'b1;
               mul_a     = mag33(lerp_diff);
               mul_b     = num_ff;
               state_in  = S_LERP_MW;
            end else if ((state_ff == S_LERP) || div_done) begin
               if (span_ff == '0) begin
                  res_in[coord_ff] = lerp_lo;
               end else if (lerp_diff[WORD_W]) begin
                  res_in[coord_ff] = lerp_lo - div_quotient[WORD_W-1:0];
               end else begin
                  res_in[coord_ff] = lerp_lo + div_quotient[WORD_W-1:0];
               end
               if (coord_ff == 2'd2) begin
                  finish = 1'b1;
               end else begin
                  coord_in = coord_ff + 1'b1;
                  state_in = S_LERP;
               end
            end
         end
         S_LERP_MW: begin
            if (mul_done) begin
               div_start = 1'b1;
               state_in  = S_LERP_DW;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      real_next = stored_in - CNT_W'(mode_in && (stored_in != '0));
      if (finish) begin
         state_in      = S_IDLE;
         rsp_valid_in  = 1'b1;
         rsp_res_in    = res_in;
         rsp_status_in = status_in;
         rsp_total_in  = total_in;
         rsp_count_in  = ANCHOR_COUNT_W'(real_next);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         mode_ff      <= 1'b0;
         stored_ff    <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         closed_ff    <= 1'b0;
         dup_ff       <= CSR_DATA_W'(1);
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         stored_ff    <= stored_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            case (csr_index)
               CSR_CLOSED_LOOP: closed_ff <= csr_wr_data[0];
               CSR_DUP_LIMIT:   dup_ff    <= csr_wr_data;
               default:         dup_ff    <= dup_ff;
            endcase
         end
      end
      func_ff       <= func_in;
      new_ff        <= new_in;
      force_ff      <= force_in;
      qparam_ff     <= qparam_in;
      status_ff     <= status_in;
      ent_a_ff      <= ent_a_in;
      ent_b_ff      <= ent_b_in;
      a_idx_ff      <= a_idx_in;
      b_idx_ff      <= b_idx_in;
      k_ff          <= k_in;
      t_ff          <= t_in;
      num_ff        <= num_in;
      span_ff       <= span_in;
      len_ff        <= len_in;
      sum_ff        <= sum_in;
      coord_ff      <= coord_in;
      phase_ff      <= phase_in;
      tsel_ff       <= tsel_in;
      tan0_ff       <= tan0_in;
      tan1_ff       <= tan1_in;
      res_ff        <= res_in;
      rsp_res_ff    <= rsp_res_in;
      rsp_status_ff <= rsp_status_in;
      rsp_total_ff  <= rsp_total_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign busy             = (state_ff != S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_x        = rsp_res_ff[0];
   assign rsp_out_y        = rsp_res_ff[1];
   assign rsp_out_z        = rsp_res_ff[2];
   assign rsp_status       = rsp_status_ff;
   assign rsp_total_length = rsp_total_ff;
   assign rsp_anchor_count = rsp_count_ff;

endmodule

### rtl/alps_checker.sv
`timescale 1ns / 1ps
// Port-level checks of the arc-length polyline sampler, bound to its top level.
// Depends on alps_pkg and arc_length_polyline_sampler_defines.svh.
`include "arc_length_polyline_sampler_defines.svh"

module alps_checker import alps_pkg::*; (
   input logic                      clock,
   input logic                      reset,
   input logic                      start,
   input logic                      busy,
   input logic                      rsp_valid,
   input logic [1:0]                rsp_status,
   input logic [WORD_W-1:0]         rsp_total_length,
   input logic [ANCHOR_COUNT_W-1:0] rsp_anchor_count
);

   `ALPS_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
   `ALPS_ASSERT_NOW(a_result_idle, rsp_valid, !busy)
   `ALPS_ASSERT_NEXT(a_single_strobe, rsp_valid, !rsp_valid)
   `ALPS_ASSERT_NOW(a_end_gives_beat, $fell(busy) && !$past(reset), rsp_valid)
   `ALPS_ASSERT_NOW(a_empty_counts, rsp_valid && (rsp_status == ST_EMPTY),
                    (rsp_anchor_count == '0) && (rsp_total_length == '0))

endmodule

bind arc_length_polyline_sampler alps_checker u_alps_checker (.*);

### dv/tb_arc_length_polyline_sampler.sv
`timescale 1ns / 1ps
// Self-checking testbench of arc_length_polyline_sampler: directed and random beats are
// predicted by a scoreboard that models the anchor store. Depends on alps_pkg and the RTL.
module tb_arc_length_polyline_sampler;
   import alps_pkg::*;

   localparam int IDLE_LIMIT = 20000;

   typedef struct {
      func_type          func;
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
      logic              force_ap;
      logic signed [31:0] param;
   } beat_t;

   typedef struct {
      logic [31:0] x;
      logic [31:0] y;
      logic [31:0] z;
      logic [1:0]  status;
      logic [31:0] total;
      logic [8:0]  count;
   } result_t;

   class curve_scoreboard;
      bit               closed_cfg;
      bit [15:0]        dup_limit;
      bit               closed_mode;
      longint           ax[DEPTH];
      longint           ay[DEPTH];
      longint           az[DEPTH];
      longint unsigned  ad[DEPTH];
      int unsigned      used;
      result_t          due[$];
      int               errors;

      function new();
         closed_cfg = 0;
         dup_limit = 1;
         closed_mode = 0;
         used = 0;
         errors = 0;
      endfunction

      function longint unsigned mg(longint d);
         return d < 0 ? longint'(-d) : d;
      endfunction

      function longint unsigned isqrt(longint unsigned n);
         longint unsigned res, b;
         res = 0;
         b = 64'd1 << 62;
         while (b > n) b >>= 2;
         while (b != 0) begin
            if (n >= res + b) begin
               n -= res + b;
               res = (res >> 1) + b;
            end else
               res >>= 1;
            b >>= 2;
         end
         return res;
      endfunction

      function longint unsigned dist3(longint dx, longint dy, longint dz);
         bit [65:0] s;
         longint unsigned a, b, c;
         a = mg(dx) * mg(dx);
         b = mg(dy) * mg(dy);
         c = mg(dz) * mg(dz);
         s = {2'b0, a} + {2'b0, b} + {2'b0, c};
         if (s[65:64] != 0) return 64'hFFFF_FFFF;
         return isqrt(s[63:0]);
      endfunction

      function longint unsigned sat_add(longint unsigned a, longint unsigned b);
         longint unsigned s;
         s = a + b;
         return s > 64'hFFFF_FFFF ? 64'hFFFF_FFFF : s;
      endfunction

      function longint lerp(longint a, longint b, longint unsigned num, longint unsigned span);
         longint d;
         longint unsigned off;
         if (span == 0) return a;
         d = b - a;
         off = mg(d) * num / span;
         return d < 0 ? a - longint'(off) : a + longint'(off);
      endfunction

      function longint tan_div(longint d, longint unsigned w);
         longint unsigned q;
         q = (mg(d) << 16) / w;
         if (d < 0) return q > 64'h8000_0000 ? -longint'(64'h8000_0000) : -longint'(q);
         return q > 64'h7FFF_FFFF ? longint'(64'h7FFF_FFFF) : longint'(q);
      endfunction

      function void entry_tangent(int unsigned idx, output longint t[3]);
         int unsigned p, r;
         longint unsigned w;
         p = idx - (idx > 0 ? 1 : 0);
         r = idx + (idx + 1 < used ? 1 : 0);
         w = ad[r] - ad[p];
         if (w == 0) begin
            t[0] = 0; t[1] = 0; t[2] = 0;
            return;
         end
         t[0] = tan_div(ax[r] - ax[p], w);
         t[1] = tan_div(ay[r] - ay[p], w);
         t[2] = tan_div(az[r] - az[p], w);
      endfunction

      function void put(int unsigned i, longint x, longint y, longint z, longint unsigned d);
         ax[i] = x; ay[i] = y; az[i] = z; ad[i] = d;
      endfunction

      function int unsigned real_count();
         return used - ((closed_mode && used != 0) ? 1 : 0);
      endfunction

      function longint unsigned length();
         return used != 0 ? ad[used-1] : 0;
      endfunction

      function void note(beat_t it);
         result_t r;
         longint res[3];
         longint t0[3], t1[3];
         longint x, y, z, q, m;
         longint unsigned len, tpar, num, span, d, back;
         int unsigned rc, a, b, k;
         res = '{0, 0, 0};
         r.status = ST_OK;
         case (it.func)
            FUNC_CLEAR: begin
               used = 0;
               closed_mode = closed_cfg;
            end
            FUNC_APPEND: begin
               x = it.x; y = it.y; z = it.z;
               rc = real_count();
               if (used == 0) begin
                  put(0, x, y, z, 0);
                  used = 1;
                  if (closed_mode) begin
                     put(1, x, y, z, 0);
                     used = 2;
                  end
               end else if (rc >= MAX_ANCHORS)
                  r.status = ST_FULL;
               else begin
                  len = dist3(x - ax[rc-1], y - ay[rc-1], z - az[rc-1]);
                  if (!it.force_ap && len < dup_limit)
                     r.status = ST_DUPLICATE;
                  else begin
                     d = sat_add(ad[rc-1], len);
                     put(rc, x, y, z, d);
                     if (closed_mode) begin
                        back = dist3(ax[0] - x, ay[0] - y, az[0] - z);
                        put(rc + 1, ax[0], ay[0], az[0], sat_add(d, back));
                        used = rc + 2;
                     end else
                        used = rc + 1;
                  end
               end
            end
            default: begin
               if (used == 0)
                  r.status = ST_EMPTY;
               else begin
                  len = ad[used-1];
                  q = it.param;
                  if (closed_mode) begin
                     if (len == 0) tpar = 0;
                     else begin
                        m = q % longint'(len);
                        if (m < 0) m += longint'(len);
                        tpar = m;
                     end
                  end else
                     tpar = q < 0 ? 0 : (q > longint'(len) ? len : longint'(q));
                  a = 0;
                  b = used - 1;
                  while (b - a > 1) begin
                     k = (a + b) / 2;
                     if (ad[k] > tpar) b = k; else a = k;
                  end
                  num = tpar - ad[a];
                  span = ad[b] - ad[a];
                  if (it.func == FUNC_POSITION) begin
                     res[0] = lerp(ax[a], ax[b], num, span);
                     res[1] = lerp(ay[a], ay[b], num, span);
                     res[2] = lerp(az[a], az[b], num, span);
                  end else begin
                     entry_tangent(a, t0);
                     entry_tangent(b, t1);
                     for (int i = 0; i < 3; i++) res[i] = lerp(t0[i], t1[i], num, span);
                  end
               end
            end
         endcase
         r.x = res[0][31:0];
         r.y = res[1][31:0];
         r.z = res[2][31:0];
         r.total = 32'(length());
         r.count = 9'(real_count());
         due = {due, r};
      endfunction

      task report(string what, logic [31:0] got, logic [31:0] want);
         $display("mismatch on %s: got %h, expected %h", what, got, want);
         errors++;
      endtask

      task check(result_t got);
         result_t w;
         if (due.size() == 0) begin
            $display("unexpected result beat");
            errors++;
            return;
         end
         w = due.pop_front();
         if (got.x !== w.x) report("out_x", got.x, w.x);
         if (got.y !== w.y) report("out_y", got.y, w.y);
         if (got.z !== w.z) report("out_z", got.z, w.z);
         if (got.status !== w.status) report("status", 32'(got.status), 32'(w.status));
         if (got.total !== w.total) report("total_length", got.total, w.total);
         if (got.count !== w.count) report("anchor_count", 32'(got.count), 32'(w.count));
      endtask
   endclass

   logic                      clock;
   logic                      reset;
   logic                      start;
   logic                      busy;
   logic [1:0]                req_func;
   logic signed [WORD_W-1:0]  req_x_coord;
   logic signed [WORD_W-1:0]  req_y_coord;
   logic signed [WORD_W-1:0]  req_z_coord;
   logic                      req_force_append;
   logic signed [WORD_W-1:0]  req_query_param;
   logic                      rsp_valid;
   logic signed [WORD_W-1:0]  rsp_out_x;
   logic signed [WORD_W-1:0]  rsp_out_y;
   logic signed [WORD_W-1:0]  rsp_out_z;
   logic [1:0]                rsp_status;
   logic [WORD_W-1:0]         rsp_total_length;
   logic [ANCHOR_COUNT_W-1:0] rsp_anchor_count;
   logic                      csr_wr_en;
   logic                      csr_index;
   logic [CSR_DATA_W-1:0]     csr_wr_data;

   curve_scoreboard sb = new();
   int idle_cycles = 0;
   logic signed [31:0] px, py, pz;

   arc_length_polyline_sampler dut (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid)
         sb.check('{rsp_out_x, rsp_out_y, rsp_out_z, rsp_status, rsp_total_length,
                    rsp_anchor_count});
   end

   always @(posedge clock) begin
      if (reset || rsp_valid || (start && !busy))
         idle_cycles <= 0;
      else if (idle_cycles >= IDLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end else
         idle_cycles <= idle_cycles + 1;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic send(beat_t it);
      int gap;
      req_func <= it.func;
      req_x_coord <= it.x;
      req_y_coord <= it.y;
      req_z_coord <= it.z;
      req_force_append <= it.force_ap;
      req_query_param <= it.param;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      sb.note(it);
      gap = pick_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_op(func_type f, logic [31:0] x, logic [31:0] y, logic [31:0] z,
                          logic fa, logic [31:0] q);
      send('{f, x, y, z, fa, q});
   endtask

   task automatic drain();
      start <= 1'b0;
      while (sb.due.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [15:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wr_data <= data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (idx == CSR_CLOSED_LOOP) sb.closed_cfg = data[0];
      else sb.dup_limit = data;
   endtask

   task automatic random_append(int wide_pct);
      int r;
      r = $urandom_range(0, 99);
      if (r < wide_pct) begin
         px = $urandom; py = $urandom; pz = $urandom;
      end else if (r < wide_pct + 10) begin
         px += $urandom_range(0, 2) - 1;
      end else begin
         px += $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
         py += $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
         pz += $urandom_range(0, 32'h0001_0000) - 32'h0000_8000;
      end
      send_op(FUNC_APPEND, px, py, pz, $urandom_range(0, 3) == 0, $urandom);
   endtask

   task automatic random_query();
      longint unsigned len;
      logic [31:0] q;
      func_type f;
      len = sb.length();
      f = $urandom_range(0, 1) ? FUNC_POSITION : FUNC_TANGENT;
      if ($urandom_range(0, 4) == 0 || len == 0) q = $urandom;
      else q = $urandom_range(0, 32'(len + len / 4)) - 32'(len / 8);
      send_op(f, $urandom, $urandom, $urandom, 1'($urandom_range(0, 1)), q);
   endtask

   task automatic random_phase(int count, int append_pct, int wide_pct);
      send_op(FUNC_CLEAR, $urandom, $urandom, $urandom, 1'($urandom_range(0, 1)), $urandom);
      px = $urandom; py = $urandom; pz = $urandom;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 99) < append_pct) random_append(wide_pct);
         else if ($urandom_range(0, 49) == 0)
            send_op(FUNC_CLEAR, $urandom, $urandom, $urandom, 0, $urandom);
         else random_query();
      end
      drain();
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_func = FUNC_CLEAR;
      req_x_coord = '0;
      req_y_coord = '0;
      req_z_coord = '0;
      req_force_append = 1'b0;
      req_query_param = '0;
      csr_wr_en = 1'b0;
      csr_index = CSR_CLOSED_LOOP;
      csr_wr_data = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_op(FUNC_POSITION, 0, 0, 0, 0, 32'h7FFF_FFFF);
      send_op(FUNC_TANGENT, 0, 0, 0, 0, 32'h8000_0000);
      send_op(FUNC_APPEND, 0, 0, 0, 0, 0);
      send_op(FUNC_POSITION, 0, 0, 0, 0, 32'h0001_0000);
      send_op(FUNC_TANGENT, 0, 0, 0, 0, 0);
      send_op(FUNC_APPEND, 0, 0, 0, 0, 0);
      send_op(FUNC_APPEND, 0, 0, 0, 1, 0);
      send_op(FUNC_APPEND, 32'h0003_0000, 32'h0004_0000, 0, 0, 0);
      send_op(FUNC_APPEND, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0);
      send_op(FUNC_APPEND, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1, 0);
      send_op(FUNC_POSITION, 0, 0, 0, 0, 32'hFFFF_FFFF);
      send_op(FUNC_POSITION, 0, 0, 0, 0, 32'h0002_8000);
      send_op(FUNC_TANGENT, 0, 0, 0, 0, 32'h0002_8000);
      send_op(FUNC_TANGENT, 0, 0, 0, 0, 32'h7FFF_FFFF);
      send_op(FUNC_CLEAR, 0, 0, 0, 0, 0);
      drain();

      write_reg(CSR_CLOSED_LOOP, 16'h0001);
      write_reg(CSR_DUP_LIMIT, 16'hFFFF);
      send_op(FUNC_CLEAR, 0, 0, 0, 0, 0);
      send_op(FUNC_APPEND, 32'h0001_0000, 0, 0, 0, 0);
      send_op(FUNC_POSITION, 0, 0, 0, 0, 32'hFFFF_0000);
      send_op(FUNC_APPEND, 32'h0001_8000, 0, 0, 0, 0);
      send_op(FUNC_APPEND, 32'h0005_0000, 32'h0003_0000, 0, 0, 0);
      send_op(FUNC_POSITION, 0, 0, 0, 0, 32'h8000_0000);
      send_op(FUNC_TANGENT, 0, 0, 0, 0, 32'hFFFF_FFFF);
      send_op(FUNC_POSITION, 0, 0, 0, 0, 32'h7FFF_FFFF);
      drain();

      write_reg(CSR_DUP_LIMIT, 16'h0000);
      random_phase(60, 50, 5);
      write_reg(CSR_CLOSED_LOOP, 16'h0000);
      write_reg(CSR_DUP_LIMIT, 16'hFFFF);
      random_phase(60, 50, 5);
      write_reg(CSR_CLOSED_LOOP, 16'h0001);
      write_reg(CSR_DUP_LIMIT, 16'h0100);
      random_phase(275, 96, 1);
      write_reg(CSR_CLOSED_LOOP, 16'h0000);
      write_reg(CSR_DUP_LIMIT, 16'($urandom));
      random_phase(50, 45, 5);

      drain();
      repeat (200) @(posedge clock);
      if (sb.errors == 0 && sb.due.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end
endmodule

### filelist.f
+incdir+rtl
rtl/alps_pkg.sv
rtl/alps_ram.sv
rtl/alps_mul.sv
rtl/alps_div.sv
rtl/alps_sqrt.sv
rtl/arc_length_polyline_sampler.sv
rtl/alps_checker.sv
dv/tb_arc_length_polyline_sampler.sv
